@@ design/skt_pkg.sv @@
package skt_pkg;

  localparam int KEY_W  = 31;
  localparam int VAL_W  = 32;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 4;
  localparam int POS_W  = 4;
  localparam int ECNT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_FIND = 2'd2,
    CMD_LIST = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INS_OK   = 4'd0,
    ST_DUP      = 4'd1,
    ST_FULL     = 4'd2,
    ST_DEL_OK   = 4'd3,
    ST_DEL_MISS = 4'd4,
    ST_HIT      = 4'd5,
    ST_MISS     = 4'd6,
    ST_ENTRY    = 4'd7,
    ST_EMPTY    = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL,
    OP_ROT
  } cell_op_t;

  typedef struct packed {
    logic     capture;
    cell_op_t op;
  } cell_ctrl_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage

@@ design/skt_cell.sv @@
module skt_cell (
  input  logic                clk,
  input  skt_pkg::cell_ctrl_t ctrl,
  input  logic [skt_pkg::KEY_W-1:0] cmp_key,
  input  skt_pkg::entry_t     new_ent,
  input  logic                held,
  input  logic                tail,
  input  logic                left_lt,
  input  skt_pkg::entry_t     left_ent,
  input  skt_pkg::entry_t     right_ent,
  input  skt_pkg::entry_t     wrap_ent,
  output skt_pkg::entry_t     ent,
  output logic                lt,
  output logic                eq,
  output logic                bnd
);

  skt_pkg::entry_t ent_r, ent_nxt;
  logic lt_r, lt_nxt;
  logic eq_r, eq_nxt;

  always_comb begin
    lt_nxt  = lt_r;
    eq_nxt  = eq_r;
    ent_nxt = ent_r;
    if (ctrl.capture) begin
      lt_nxt = held && (ent_r.key < cmp_key);
      eq_nxt = held && (ent_r.key == cmp_key);
    end
    case (ctrl.op)
      skt_pkg::OP_INS: begin
        // cells at and above the insert point move up one; the boundary cell loads
        if (!lt_r) ent_nxt = left_lt ? new_ent : left_ent;
      end
      skt_pkg::OP_DEL: begin
        if (!lt_r) ent_nxt = right_ent;
      end
      skt_pkg::OP_ROT: begin
        // rotate the held cells left; the head wraps to the tail
        if (held) ent_nxt = tail ? wrap_ent : right_ent;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    lt_r  <= lt_nxt;
    eq_r  <= eq_nxt;
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;
  assign lt  = lt_r;
  assign eq  = eq_r;
  assign bnd = !lt_r && left_lt;

endmodule

@@ design/sorted_key_table.sv @@
// Sorted key table: holds up to CAPACITY entries (unique key plus value handle)
// in a row of cells kept in ascending key order. Each cell compares its key
// against the incoming key at the cycle the item is accepted; once the output
// register is free the row shifts in one step (insert opens a slot, delete closes
// one) and the single result is written to the output register. List emits one
// result per held entry, one per cycle while out_stall allows, by rotating the
// held cells past the head cell, and returns the row to its original order; an
// empty table gives one empty result. The input is stalled from acceptance until
// the last result of that item is loaded into the output register, which may
// still be waiting on out_stall when the next item enters.
module sorted_key_table #(
  parameter int CAPACITY = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [skt_pkg::CMD_W-1:0]    in_cmd,
  input  logic [skt_pkg::KEY_W-1:0]    in_key,
  input  logic [skt_pkg::VAL_W-1:0]    in_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [skt_pkg::STAT_W-1:0]   out_status,
  output logic [skt_pkg::KEY_W-1:0]    out_key_out,
  output logic [skt_pkg::VAL_W-1:0]    out_value_out,
  output logic [skt_pkg::POS_W-1:0]    out_position,
  output logic [skt_pkg::ECNT_W-1:0]   out_entry_count,
  output logic                         out_last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PW    = skt_pkg::POS_W;
  localparam int ECW   = skt_pkg::ECNT_W;
  localparam int VW    = skt_pkg::VAL_W;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_LIST} state_t;

  state_t                     state_r, state_nxt;
  skt_pkg::cmd_t              cmd_r, cmd_nxt;
  logic [skt_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [VW-1:0]              val_r, val_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [CNT_W-1:0]           lst_idx_r, lst_idx_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [skt_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [skt_pkg::KEY_W-1:0]  okey_r, okey_nxt;
  logic [VW-1:0]              oval_r, oval_nxt;
  logic [PW-1:0]              pos_r, pos_nxt;
  logic [ECW-1:0]             ecnt_r, ecnt_nxt;
  logic                       last_r, last_nxt;

  skt_pkg::cell_ctrl_t        ctrl;
  skt_pkg::entry_t            new_ent;
  skt_pkg::entry_t            ent   [CAPACITY];
  logic [CAPACITY-1:0]        lt_vec, eq_vec, bnd_vec;

  logic                       accept, slot_free, hit, full;
  logic [PW-1:0]              pos_enc;
  logic [VW-1:0]              hit_val;

  assign accept    = in_valid && (state_r == S_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign hit       = |eq_vec;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign new_ent   = '{key: key_r, value: val_r};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    skt_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .cmp_key   (in_key),
      .new_ent   (new_ent),
      .held      (count_r > CNT_W'(i)),
      .tail      (count_r == CNT_W'(i + 1)),
      .left_lt   ((i == 0) ? 1'b1 : lt_vec[(i == 0) ? 0 : i - 1]),
      .left_ent  ((i == 0) ? new_ent : ent[(i == 0) ? 0 : i - 1]),
      .right_ent ((i == CAPACITY - 1) ? new_ent : ent[(i == CAPACITY - 1) ? i : i + 1]),
      .wrap_ent  (ent[0]),
      .ent       (ent[i]),
      .lt        (lt_vec[i]),
      .eq        (eq_vec[i]),
      .bnd       (bnd_vec[i])
    );
  end

  // boundary and match vectors each have at most one bit set, so OR-encode them
  always_comb begin
    pos_enc = '0;
    hit_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (bnd_vec[i]) pos_enc = pos_enc | PW'(i);
      if (eq_vec[i])  hit_val = hit_val | ent[i].value;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    count_nxt     = count_r;
    lst_idx_nxt   = lst_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    okey_nxt      = okey_r;
    oval_nxt      = oval_r;
    pos_nxt       = pos_r;
    ecnt_nxt      = ecnt_r;
    last_nxt      = last_r;
    ctrl.capture  = accept;
    ctrl.op       = skt_pkg::OP_HOLD;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt   = skt_pkg::cmd_t'(in_cmd);
          key_nxt   = in_key;
          val_nxt   = in_value;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          okey_nxt      = key_r;
          oval_nxt      = '0;
          pos_nxt       = '0;
          last_nxt      = 1'b1;
          ecnt_nxt      = ECW'(count_r);
          state_nxt     = S_IDLE;
          case (cmd_r)
            skt_pkg::CMD_INS: begin
              if (hit) begin
                status_nxt = skt_pkg::ST_DUP;
                pos_nxt    = pos_enc;
              end else if (full) begin
                status_nxt = skt_pkg::ST_FULL;
              end else begin
                status_nxt = skt_pkg::ST_INS_OK;
                pos_nxt    = pos_enc;
                ctrl.op    = skt_pkg::OP_INS;
                count_nxt  = count_r + CNT_W'(1);
                ecnt_nxt   = ECW'(count_nxt);
              end
            end
            skt_pkg::CMD_DEL: begin
              if (hit) begin
                status_nxt = skt_pkg::ST_DEL_OK;
                pos_nxt    = pos_enc;
                ctrl.op    = skt_pkg::OP_DEL;
                count_nxt  = count_r - CNT_W'(1);
                ecnt_nxt   = ECW'(count_nxt);
              end else begin
                status_nxt = skt_pkg::ST_DEL_MISS;
              end
            end
            skt_pkg::CMD_FIND: begin
              if (hit) begin
                status_nxt = skt_pkg::ST_HIT;
                pos_nxt    = pos_enc;
                oval_nxt   = hit_val;
              end else begin
                status_nxt = skt_pkg::ST_MISS;
              end
            end
            default: begin
              if (count_r == '0) begin
                status_nxt = skt_pkg::ST_EMPTY;
                okey_nxt   = '0;
              end else begin
                status_nxt  = skt_pkg::ST_ENTRY;
                okey_nxt    = ent[0].key;
                oval_nxt    = ent[0].value;
                ctrl.op     = skt_pkg::OP_ROT;
                last_nxt    = (count_r == CNT_W'(1));
                lst_idx_nxt = CNT_W'(1);
                if (count_r != CNT_W'(1)) state_nxt = S_LIST;
              end
            end
          endcase
        end
      end
      S_LIST: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          status_nxt    = skt_pkg::ST_ENTRY;
          okey_nxt      = ent[0].key;
          oval_nxt      = ent[0].value;
          pos_nxt       = PW'(lst_idx_r);
          ecnt_nxt      = ECW'(count_r);
          last_nxt      = ((lst_idx_r + CNT_W'(1)) == count_r);
          ctrl.op       = skt_pkg::OP_ROT;
          lst_idx_nxt   = lst_idx_r + CNT_W'(1);
          if (last_nxt) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    val_r     <= val_nxt;
    lst_idx_r <= lst_idx_nxt;
    status_r  <= status_nxt;
    okey_r    <= okey_nxt;
    oval_r    <= oval_nxt;
    pos_r     <= pos_nxt;
    ecnt_r    <= ecnt_nxt;
    last_r    <= last_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_key_out     = okey_r;
  assign out_value_out   = oval_r;
  assign out_position    = pos_r;
  assign out_entry_count = ecnt_r;
  assign out_last        = last_r;

endmodule

@@ design/skt_checker.sv @@
module skt_checker #(
  parameter int CAPACITY = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [skt_pkg::STAT_W-1:0]   out_status,
  input logic [skt_pkg::VAL_W-1:0]    out_value_out,
  input logic [skt_pkg::POS_W-1:0]    out_position,
  input logic [skt_pkg::ECNT_W-1:0]   out_entry_count,
  input logic                         out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken before first finished");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != skt_pkg::ST_ENTRY) |-> out_last)
    else $error("single result without last");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == skt_pkg::ST_FULL || out_status == skt_pkg::ST_DEL_MISS ||
                  out_status == skt_pkg::ST_MISS)
    |-> (out_position == '0) && (out_value_out == '0))
    else $error("miss result carries position or value");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_entry_count) <= CAPACITY)
    else $error("entry count above capacity");

endmodule

bind sorted_key_table skt_checker #(.CAPACITY(CAPACITY)) u_skt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_value_out   (out_value_out),
  .out_position    (out_position),
  .out_entry_count (out_entry_count),
  .out_last        (out_last)
);
